// File: rtl/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and helpers of the first-fit bin allocator
// Holds the bin count, the tree entry type, the compare functions of the
// descent and the replay, and the leftmost-leaf helper of the clear sweep.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int NUM_BINS   = 64;
	localparam int LEAF_LOG   = $clog2(NUM_BINS);
	localparam int LEAF_COUNT = 1 << LEAF_LOG;
	localparam int BIN_W      = LEAF_LOG;
	localparam int LVL_W      = (LEAF_LOG > 1) ? $clog2(LEAF_LOG) : 1;
	localparam int SIZE_W     = 16;
	localparam int IDX_W      = 6;

	localparam logic [SIZE_W-1:0] CAP_RESET = 16'd255;

	typedef logic [BIN_W-1:0]  bin_t;
	typedef logic [BIN_W-1:0]  node_t;
	typedef logic [LVL_W-1:0]  lvl_t;
	typedef logic [SIZE_W-1:0] space_t;

	// One tree node: the winning bin below it and that bin's free space.
	typedef struct packed {
		bin_t   bin;
		space_t space;
	} entry_t;

	// Padding leaves above the real bin count are absent.
	function automatic logic present(input bin_t b);
		return (BIN_W + 1)'(b) < (BIN_W + 1)'(NUM_BINS);
	endfunction

	function automatic logic fits(input entry_t e, input space_t size);
		return present(e.bin) && (e.space >= size);
	endfunction

	// Max winner, ties to the left (lower-numbered) side.
	function automatic entry_t match(input entry_t a, input entry_t b);
		if (present(a.bin) && (!present(b.bin) || (a.space >= b.space))) begin
			return a;
		end
		return b;
	endfunction

	// Leftmost leaf below a node: shift the node number up until its top bit
	// reaches the top, then drop that bit and append a zero.
	function automatic bin_t leftmost_leaf(input node_t n);
		node_t v;
		v = n;
		for (int k = 0; k < LEAF_LOG - 1; k++) begin
			if (!v[LEAF_LOG-1]) begin
				v = v << 1;
			end
		end
		return {v[LEAF_LOG-2:0], 1'b0};
	endfunction

endpackage
`default_nettype wire

// File: rtl/ffba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

// File: rtl/first_fit_bin_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_bin_allocator_top: first-fit bin allocator with a winner tree
// Keeps the free space of every bin and a max-winner tree over the bins, and
// places each requested item into the lowest-numbered bin that can hold it.
// ----------------------------------------------------------------------------
// Usage. Three valid/ready channels share clk and the asynchronous reset
// arst_n. The configuration channel writes the bin capacity (cfg_data); it
// is always ready and the value takes effect at the next clear request. The
// input channel carries one request: mode 0 places an item of item_size,
// mode 1 reloads every bin with the capacity. The output channel returns one
// result per request: the chosen bin, the space left in it and a no_fit flag.
// Sequence: a place request runs from its acceptance through the root check,
// a descent that reads both children of each node on its path through the
// tree and bin RAMs, a write-back that replays the winners up to the root,
// the result state and a return to idle for the next handshake, and no new
// request is taken before it is through. An item that fits no bin goes from
// the root check straight to the result state. A clear request sweeps all
// 64 entries of both RAMs, one a cycle. The tree RAM's single write port sets
// the replay length, its read latency the descent length.
// Reset: after arst_n is released the block runs the same sweep over all 64
// entries with the reset capacity of 255 and accepts no request meanwhile.
// Stall: the result sits in an output register; the next request is taken
// while it waits, and its own result waits until the receiver takes the
// earlier one.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ffba_pkg::SIZE_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [ffba_pkg::SIZE_W-1:0]   item_size,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ffba_pkg::IDX_W-1:0]    bin_index,
	output logic      [ffba_pkg::SIZE_W-1:0]   space_left,
	output logic                               no_fit
);

	import ffba_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CHECK,
		ST_DESC,
		ST_REPLAY,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic                 init_q;
	node_t                sw_q;
	space_t               cap_q;
	space_t               size_q;
	node_t                node_q;
	lvl_t                 lvl_q;
	logic [LEAF_LOG-1:0]  dir_q;
	entry_t               sib_q [LEAF_LOG];
	entry_t               cur_q;
	logic [IDX_W-1:0]     res_bin_q;
	space_t               res_space_q;
	logic                 res_nofit_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_bin_q;
	space_t               out_space_q;
	logic                 out_nofit_q;

	// RAM ports
	logic   tree_we, bin_we;
	node_t  tree_waddr, tree_ra_a, child_l, child_r, rd_node;
	bin_t   bin_waddr;
	entry_t tree_wdata, tree_rd_a, tree_rd_b;
	space_t bin_wdata, bin_rd_a, bin_rd_b;

	// Datapath
	logic   in_fire, leaf_lvl, go_left, root_fit, last_sweep, rep_dir;
	entry_t left_e, right_e, take_e, sib_e, rep_l, rep_r, rep_w;
	node_t  next_node;
	space_t new_space, sweep_cap;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign bin_index  = out_bin_q;
	assign space_left = out_space_q;
	assign no_fit     = out_nofit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Both children of the node being walked come out of both RAMs at once;
	// the level decides whether they are tree nodes or leaves.
	always_comb begin
		leaf_lvl  = (lvl_q == lvl_t'(LEAF_LOG - 1));
		if (leaf_lvl) begin
			left_e  = '{bin: {node_q[LEAF_LOG-2:0], 1'b0}, space: bin_rd_a};
			right_e = '{bin: {node_q[LEAF_LOG-2:0], 1'b1}, space: bin_rd_b};
		end else begin
			left_e  = tree_rd_a;
			right_e = tree_rd_b;
		end
		go_left   = fits(left_e, size_q);
		take_e    = go_left ? left_e : right_e;
		sib_e     = go_left ? right_e : left_e;
		next_node = {node_q[LEAF_LOG-2:0], ~go_left};
		new_space = take_e.space - size_q;
		root_fit  = fits(tree_rd_a, size_q);

		rep_dir   = dir_q[lvl_q];
		rep_l     = rep_dir ? sib_q[lvl_q] : cur_q;
		rep_r     = rep_dir ? cur_q : sib_q[lvl_q];
		rep_w     = match(rep_l, rep_r);

		last_sweep = (sw_q == node_t'(LEAF_COUNT - 1));
		sweep_cap  = init_q ? CAP_RESET : cap_q;

		rd_node   = (state_q == ST_CHECK) ? node_t'(1) : next_node;
		child_l   = {rd_node[LEAF_LOG-2:0], 1'b0};
		child_r   = {rd_node[LEAF_LOG-2:0], 1'b1};
		tree_ra_a = (state_q == ST_IDLE) ? node_t'(1) : child_l;

		tree_we    = 1'b0;
		tree_waddr = node_q;
		tree_wdata = rep_w;
		bin_we     = 1'b0;
		bin_waddr  = take_e.bin;
		bin_wdata  = new_space;

		case (state_q)
			ST_SWEEP: begin
				tree_we    = 1'b1;
				tree_waddr = sw_q;
				tree_wdata = '{bin: leftmost_leaf(sw_q), space: sweep_cap};
				bin_we     = 1'b1;
				bin_waddr  = sw_q;
				bin_wdata  = sweep_cap;
			end
			ST_DESC: begin
				bin_we = leaf_lvl && present(take_e.bin);
			end
			ST_REPLAY: begin
				tree_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ffba_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(LEAF_COUNT)
	) u_tree_ram (
		.clk     (clk),
		.we      (tree_we),
		.waddr   (tree_waddr),
		.wdata   (tree_wdata),
		.raddr_a (tree_ra_a),
		.raddr_b (child_r),
		.rdata_a (tree_rd_a),
		.rdata_b (tree_rd_b)
	);

	ffba_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(LEAF_COUNT)
	) u_bin_ram (
		.clk     (clk),
		.we      (bin_we),
		.waddr   (bin_waddr),
		.wdata   (bin_wdata),
		.raddr_a (child_l),
		.raddr_b (child_r),
		.rdata_a (bin_rd_a),
		.rdata_b (bin_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_q      <= 1'b1;
			sw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the result state the output register is handled below.
			if (out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sw_q <= sw_q + node_t'(1);
					if (last_sweep) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							res_bin_q   <= '0;
							res_space_q <= '0;
							res_nofit_q <= 1'b0;
							state_q     <= ST_DONE;
						end
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						size_q <= item_size;
						if (mode) begin
							sw_q    <= '0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (!root_fit) begin
						res_bin_q   <= '0;
						res_space_q <= '0;
						res_nofit_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						node_q  <= node_t'(1);
						lvl_q   <= '0;
						state_q <= ST_DESC;
					end
				end
				ST_DESC: begin
					dir_q[lvl_q] <= ~go_left;
					sib_q[lvl_q] <= sib_e;
					if (leaf_lvl) begin
						if (!present(take_e.bin)) begin
							res_bin_q   <= '0;
							res_space_q <= '0;
							res_nofit_q <= 1'b1;
							state_q     <= ST_DONE;
						end else begin
							res_bin_q   <= IDX_W'(take_e.bin);
							res_space_q <= new_space;
							res_nofit_q <= 1'b0;
							cur_q       <= '{bin: take_e.bin, space: new_space};
							state_q     <= ST_REPLAY;
						end
					end else begin
						node_q <= next_node;
						lvl_q  <= lvl_q + lvl_t'(1);
					end
				end
				ST_REPLAY: begin
					cur_q  <= rep_w;
					node_q <= node_q >> 1;
					if (lvl_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						lvl_q <= lvl_q - lvl_t'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_bin_q   <= res_bin_q;
						out_space_q <= res_space_q;
						out_nofit_q <= res_nofit_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
